### hw/rtl/shp3_pkg.sv
// Shared constants, types and helpers for the 3x3 sharpen filter.
package shp3_pkg;

  // Line and frame limits
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH + 2;
  localparam int COL_W       = $clog2(STORE_DEPTH);
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_W       = HEIGHT_W;

  // Pixel word layout in the line stores: {sel, a, r, g, b}
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 4 * CHAN_W + 1;
  localparam int SH_B   = 0;
  localparam int SH_G   = CHAN_W;
  localparam int SH_R   = 2 * CHAN_W;
  localparam int SH_A   = 3 * CHAN_W;
  localparam int SH_SEL = 4 * CHAN_W;

  // Stream and config word widths
  localparam int DATA_W   = 4 * CHAN_W;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = HEIGHT_W;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 8'd0,
    REG_HEIGHT = 8'd1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // One colour channel of a packed pixel
  function automatic chan_t chan_of(input pix_t px, input int shift);
    chan_of = px[shift +: CHAN_W];
  endfunction

endpackage

### hw/rtl/shp3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module shp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sharpen_3x3_rgb_filter_top.sv
// 3x3 sharpen filter top level: line stores, window, sharpen datapath and stream ports.
//
// Takes a bordered RGBA frame of (image_width + 2) x (image_height + 2) pixels,
// one word per accepted beat, row by row, and emits one word per interior pixel:
// each colour is 9 * centre minus its eight neighbours, clamped to 0..255, for a
// selected centre, or the centre's colour unchanged otherwise; alpha is the centre's.
// Sustained rate is one pixel per clock while out_tready stays high. A result shows
// on out_tvalid once the input word completing its window has passed the line-store
// read with stage 1, the window update and the output register; border positions produce no output.
// out_tlast marks the last pixel of a row, out_tuser the last pixel of the frame.
// A config write to the width or height register restarts the frame.
module sharpen_3x3_rgb_filter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [shp3_pkg::DATA_W-1:0]    in_tdata,   // red, green, blue, alpha
  input  logic                           in_tuser,   // selected
  // output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [shp3_pkg::DATA_W-1:0]    out_tdata,  // red, green, blue, alpha
  output logic                           out_tlast,  // row end
  output logic                           out_tuser,  // frame end
  // config writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [shp3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shp3_pkg::CFG_DAT_W-1:0] cfg_data
);
  import shp3_pkg::*;

  // Config registers
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                cfg_fire;

  // Last bordered positions of the effective sizes
  logic [WIDTH_W-1:0]  col_last;
  logic [HEIGHT_W-1:0] row_last;

  // Input position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_fire;
  pix_t             in_pix;

  // Stage 1: pixel waiting for line-store data
  logic             s1_valid_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_adv;
  pix_t             rd_upper, rd_middle;

  // Stage 2: window holding a centre that produces a result
  pix_t win_r [9];
  logic s2_valid_r;
  logic s2_row_end_r;
  logic s2_frame_end_r;
  logic s2_adv;

  // Output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;
  logic              out_user_r;
  logic [DATA_W-1:0] res_data;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // Clamp width to 1..MAX_WIDTH and height to 1..MAX_HEIGHT, add border
  always_comb begin
    if (width_r == '0) begin
      col_last = WIDTH_W'(2);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      col_last = WIDTH_W'(MAX_WIDTH + 1);
    end else begin
      col_last = width_r + WIDTH_W'(1);
    end
    if (height_r == '0) begin
      row_last = HEIGHT_W'(2);
    end else if (height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      row_last = HEIGHT_W'(MAX_HEIGHT + 1);
    end else begin
      row_last = height_r + HEIGHT_W'(1);
    end
  end

  // Handshake chain, back to front
  assign s2_adv    = s2_valid_r & (~out_valid_r | out_tready);
  assign s1_adv    = s1_valid_r & (~s2_valid_r | s2_adv);
  assign in_tready = ~s1_valid_r | s1_adv;
  assign in_fire   = in_tvalid & in_tready;

  assign in_pix = {in_tuser, in_tdata[4*CHAN_W-1 -: CHAN_W], in_tdata[CHAN_W-1:0],
                   in_tdata[2*CHAN_W-1 -: CHAN_W], in_tdata[3*CHAN_W-1 -: CHAN_W]};

  // Position in the bordered frame
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_r == COL_W'(col_last)) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Config registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(640);
      height_r <= HEIGHT_W'(480);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_WIDTH: begin
          width_r <= cfg_data[WIDTH_W-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_HEIGHT: begin
          height_r <= cfg_data;
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
          col_r <= col_nxt;
          row_r <= row_nxt;
        end
      endcase
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: read on accept, write back when the window takes the column
  shp3_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (rd_middle),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (rd_upper)
  );

  shp3_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (rd_middle)
  );

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= in_pix;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // Window shift; new right column from the line stores and the new pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]     <= win_r[k*3 + 1];
        win_r[k*3 + 1] <= win_r[k*3 + 2];
      end
      win_r[2] <= rd_upper;
      win_r[5] <= rd_middle;
      win_r[8] <= s1_pix_r;
    end
  end

  // Stage 2 control: a result exists for interior centres only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= (s1_col_r >= COL_W'(2)) && (s1_row_r >= ROW_W'(2));
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_row_end_r   <= (s1_col_r == COL_W'(col_last));
      s2_frame_end_r <= (s1_col_r == COL_W'(col_last)) && (s1_row_r == row_last);
    end
  end

  // Sharpen datapath: 9 * centre - neighbours, clamped
  always_comb begin
    logic [11:0] nsum;
    logic [12:0] acc;
    chan_t       ch [3];
    int          sh [3];
    sh[0] = SH_R;
    sh[1] = SH_G;
    sh[2] = SH_B;
    for (int j = 0; j < 3; j++) begin
      nsum = '0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) begin
          nsum = nsum + 12'(chan_of(win_r[k], sh[j]));
        end
      end
      acc = {1'b0, 12'(chan_of(win_r[4], sh[j])) * 12'd9} - {1'b0, nsum};
      if (!win_r[4][SH_SEL]) begin
        ch[j] = chan_of(win_r[4], sh[j]);
      end else if (acc[12]) begin
        ch[j] = '0;
      end else if (acc[11:0] > 12'd255) begin
        ch[j] = chan_t'(255);
      end else begin
        ch[j] = acc[CHAN_W-1:0];
      end
    end
    res_data = {chan_of(win_r[4], SH_A), ch[2], ch[1], ch[0]};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data_r <= res_data;
      out_last_r <= s2_row_end_r;
      out_user_r <= s2_frame_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

### test/tb_sharpen_3x3_rgb_filter_top.sv
// Self-checking stream testbench for the 3x3 sharpen filter top level.
module tb_sharpen_3x3_rgb_filter_top;
  import shp3_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_WORDS   = 1000;
  // index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  row_end;
    logic  frame_end;
  } sharp_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata;   // red, green, blue, alpha
  logic                 in_tuser;   // selected
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DATA_W-1:0]    out_tdata;  // red, green, blue, alpha
  logic                 out_tlast;  // row end
  logic                 out_tuser;  // frame end
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  sharpen_3x3_rgb_filter_top dut (.*);

  // shadow copy of the filter state
  pix_t                upper_line [STORE_DEPTH];
  pix_t                middle_line [STORE_DEPTH];
  pix_t                window [9];   // row * 3 + col, col 2 newest
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  sharp_word_t sharpened_q[$];

  int send_idle_pct = 7;
  int recv_idle_pct = 55;
  int hold_reqs     = 0;
  int errors        = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int frames_seen   = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic void reset_shadow();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int k = 0; k < 9; k++) window[k] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = 11'd640;
    height_reg = 13'd480;
  endfunction

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int frame_words();
    return (active_width() + 2) * (active_height() + 2);
  endfunction

  // 9 * centre minus the ring, clamped to a byte
  function automatic chan_t sharpen_chan(int shift);
    int acc;
    acc = 9 * int'(window[4][shift +: CHAN_W]);
    for (int k = 0; k < 9; k++)
      if (k != 4) acc -= int'(window[k][shift +: CHAN_W]);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return chan_t'(acc);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    if (idx == REG_WIDTH)
      width_reg = val[WIDTH_W-1:0];
    else if (idx == REG_HEIGHT)
      height_reg = val;
    else
      return;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // advance the window by one accepted word, queue the result it completes
  function automatic void track_pixel(pix_t px);
    int unsigned w, h, c, r;
    pix_t        ctr;
    sharp_word_t res;
    w = active_width();
    h = active_height();
    c = (col_pos > w + 1) ? w + 1 : col_pos;
    r = (row_pos > h + 1) ? h + 1 : row_pos;
    for (int k = 0; k < 3; k++) begin
      window[k*3]   = window[k*3+1];
      window[k*3+1] = window[k*3+2];
    end
    window[2]      = upper_line[c];
    window[5]      = middle_line[c];
    window[8]      = px;
    upper_line[c]  = middle_line[c];
    middle_line[c] = px;
    if (r >= 2 && c >= 2) begin
      ctr = window[4];
      if (ctr[SH_SEL]) begin
        res.red   = sharpen_chan(SH_R);
        res.green = sharpen_chan(SH_G);
        res.blue  = sharpen_chan(SH_B);
      end else begin
        res.red   = ctr[SH_R +: CHAN_W];
        res.green = ctr[SH_G +: CHAN_W];
        res.blue  = ctr[SH_B +: CHAN_W];
      end
      res.alpha     = ctr[SH_A +: CHAN_W];
      res.row_end   = (c == w + 1);
      res.frame_end = (c == w + 1) && (r == h + 1);
      sharpened_q.push_back(res);
    end
    if (c >= w + 1) begin
      col_pos = 0;
      row_pos = (r >= h + 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic chan_t rand_chan();
    case ($urandom_range(7, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return chan_t'($urandom());
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t px;
    px[SH_R +: CHAN_W] = rand_chan();
    px[SH_G +: CHAN_W] = rand_chan();
    px[SH_B +: CHAN_W] = rand_chan();
    px[SH_A +: CHAN_W] = rand_chan();
    px[SH_SEL]         = ($urandom_range(3, 0) != 0);
    return px;
  endfunction

  // offer one pixel word, with random gaps ahead of it
  task automatic send_pixel(pix_t px);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {px[SH_A +: CHAN_W], px[SH_B +: CHAN_W],
                 px[SH_G +: CHAN_W], px[SH_R +: CHAN_W]};
    in_tuser  = px[SH_SEL];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_pixel(px);
    words_sent++;
  endtask

  // register write once the pipeline has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sharpened_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic stream_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // part of a 3x3 frame: one ring colour around one centre
  task automatic send_grid(pix_t ring, pix_t ctr, int first, int last);
    for (int i = first; i <= last; i++) send_pixel((i == 4) ? ctr : ring);
  endtask

  // ---------------- tests ----------------

  // zero sizes act as one; clamp at both ends, flat area, unselected pass-through
  task automatic test_clamp_extremes();
    pix_t ring, ctr;
    ring = {1'b1, 8'h00, 8'h00, 8'hFF, 8'h64};
    ctr  = {1'b1, 8'hA5, 8'hFF, 8'h00, 8'h64};
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, '0);
    send_grid(ring, ctr, 0, 8);
    ctr[SH_SEL] = 1'b0;
    send_grid(ring, ctr, 0, 8);
  endtask

  // a write to an unknown index mid-frame must not restart the frame
  task automatic test_unknown_register();
    pix_t ring, ctr;
    ring = {1'b0, 8'h5A, 8'h10, 8'h80, 8'hFF};
    ctr  = {1'b1, 8'hFF, 8'h40, 8'h90, 8'h00};
    send_grid(ring, ctr, 0, 3);
    write_reg(REG_NONE, '1);
    send_grid(ring, ctr, 4, 8);
  endtask

  // oversize registers clamp; each run is cut short to keep the word count low
  task automatic test_size_limits();
    // oversize width: part of the first bordered row only
    write_reg(REG_WIDTH, '1);
    write_reg(REG_HEIGHT, 13'd1);
    stream_pixels(MAX_WIDTH / 8);
    // oversize height: forty narrow rows, no frame end may appear
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, '1);
    stream_pixels(3 * 40);
    // exact maxima, start of the first row
    write_reg(REG_WIDTH, CFG_DAT_W'(MAX_WIDTH));
    write_reg(REG_HEIGHT, CFG_DAT_W'(MAX_HEIGHT));
    stream_pixels(64);
  endtask

  // mostly small whole frames with random content, some cut short;
  // upper data bits of the width write are dropped
  task automatic test_random_frames(int quota);
    int                   target, words;
    logic [CFG_DAT_W-1:0] wd;
    bit                   cut;
    target = words_sent + quota;
    cut    = 1'b1;
    while (words_sent < target) begin
      if (cut || $urandom_range(3, 0) != 0) begin
        wd = ($urandom_range(9, 0) == 0) ? CFG_DAT_W'($urandom_range(64, 13))
                                         : CFG_DAT_W'($urandom_range(12, 0));
        wd[CFG_DAT_W-1:WIDTH_W] = 2'($urandom_range(3, 0));
        write_reg(REG_WIDTH, wd);
        write_reg(REG_HEIGHT, CFG_DAT_W'($urandom_range(5, 0)));
      end
      words = frame_words();
      cut   = ($urandom_range(9, 0) == 0);
      if (cut) words = $urandom_range(words - 1, 1);
      stream_pixels(words);
    end
  endtask

  // receiver holds off long enough for the filter to fill and stall its input
  task automatic test_output_backpressure();
    write_reg(REG_WIDTH, 13'd40);
    write_reg(REG_HEIGHT, 13'd12);
    hold_reqs++;
    stream_pixels(frame_words());
  endtask

  // ---------------- receiver ----------------

  initial begin : receiver
    int hold_left;
    int seen;
    hold_left  = 0;
    seen       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (seen != hold_reqs) begin
        seen      = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // ---------------- result checker ----------------

  always @(posedge clk) begin : check_result
    sharp_word_t got;
    sharp_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.red       = out_tdata[7:0];
      got.green     = out_tdata[15:8];
      got.blue      = out_tdata[23:16];
      got.alpha     = out_tdata[31:24];
      got.row_end   = out_tlast;
      got.frame_end = out_tuser;
      if (sharpened_q.size() == 0) begin
        $display("%0t: unexpected word r=%0d g=%0d b=%0d a=%0d row_end=%0b frame_end=%0b",
                 $time, got.red, got.green, got.blue, got.alpha, got.row_end, got.frame_end);
        errors++;
      end else begin
        want = sharpened_q.pop_front();
        words_checked++;
        if (want.frame_end) frames_seen++;
        if (got !== want) begin
          $display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d row_end=%0b frame_end=%0b",
                   $time, want.red, want.green, want.blue, want.alpha,
                   want.row_end, want.frame_end);
          $display("%0t:          actual   r=%0d g=%0d b=%0d a=%0d row_end=%0b frame_end=%0b",
                   $time, got.red, got.green, got.blue, got.alpha,
                   got.row_end, got.frame_end);
          errors++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data  = '0;
    reset_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_clamp_extremes();
    test_unknown_register();
    test_size_limits();

    // random frames under three idle patterns
    send_idle_pct = 7;
    recv_idle_pct = 55;
    test_random_frames(RANDOM_WORDS / 3);
    send_idle_pct = 55;
    recv_idle_pct = 7;
    test_random_frames(RANDOM_WORDS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(RANDOM_WORDS / 3);

    test_output_backpressure();

    // drain and watch for stray words
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Sent %0d pixel words and %0d register writes; checked %0d filtered words",
             words_sent, cfg_writes, words_checked);
    $display("including %0d complete frames; %0d errors", frames_seen, errors);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
hw/rtl/shp3_pkg.sv
hw/rtl/shp3_ram.sv
hw/rtl/sharpen_3x3_rgb_filter_top.sv
test/tb_sharpen_3x3_rgb_filter_top.sv
